[hw/rtl/bfhs_pkg.sv]
// shared types and constants for the back/forward history stacks
package bfhs_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int PAGE_BITS   = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic [1:0] MODE_VISIT   = 2'd0;
  localparam logic [1:0] MODE_BACK    = 2'd1;
  localparam logic [1:0] MODE_FORWARD = 2'd2;

  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_NO_BACK    = 2'd1;
  localparam logic [1:0] ST_NO_FORWARD = 2'd2;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // per-cell shift controls
  typedef struct packed {
    logic shift_down;
    logic shift_up;
  } cell_ctl_t;

  // per-stack operation
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stk_ctl_t;

endpackage

[hw/rtl/back_forward_history_stacks.sv]
// top level of the back/forward navigation history block
// The block keeps a current page and two bounded history stacks (back and
// forward), each a row of STACK_DEPTH cells that shift as one: a push moves
// every entry one cell down, a pop moves every entry one cell up, so the top
// of each stack always sits in cell 0 and no address decode is needed. One
// transaction is taken every cycle unless stalled; its result shows on the
// output in the cycle after acceptance, from an output register. The input
// is ready whenever the output register is empty or being drained, so a
// stalled output holds the input back after one item. After reset the home
// page (0) is current and both stacks are empty; no clearing pass is needed.
module back_forward_history_stacks
  import bfhs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [1:0] mode, [17:2] page_id
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [15:0] current_page, [17:16] status
);

  // input fields
  logic [1:0]  in_mode;
  logic [15:0] in_page_id;
  logic        in_acc;

  assign in_mode    = in_tdata[1:0];
  assign in_page_id = in_tdata[17:2];

  // state
  page_t    cur_r, cur_nxt;
  stk_ctl_t back_ctl, fwd_ctl;
  page_t    back_top, fwd_top;
  logic     back_empty, fwd_empty;
  logic [1:0] status_nxt;

  // output register
  logic        out_valid_r;
  logic [15:0] out_page_r;
  logic [1:0]  out_status_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // step decode: stack controls, next current page, status
  always_comb begin
    back_ctl   = '0;
    fwd_ctl    = '0;
    cur_nxt    = cur_r;
    status_nxt = ST_DONE;
    unique case (in_mode)
      MODE_VISIT: begin
        back_ctl.push = 1'b1;
        fwd_ctl.clear = 1'b1;
        cur_nxt       = PAGE_BITS'(in_page_id);
      end
      MODE_BACK: begin
        if (back_empty) begin
          status_nxt = ST_NO_BACK;
        end else begin
          fwd_ctl.push = 1'b1;
          back_ctl.pop = 1'b1;
          cur_nxt      = back_top;
        end
      end
      MODE_FORWARD: begin
        if (fwd_empty) begin
          status_nxt = ST_NO_FORWARD;
        end else begin
          back_ctl.push = 1'b1;
          fwd_ctl.pop   = 1'b1;
          cur_nxt       = fwd_top;
        end
      end
      default: begin
        // unused mode code: nothing changes
      end
    endcase
    // only an accepted transaction touches the stacks
    if (!in_acc) begin
      back_ctl = '0;
      fwd_ctl  = '0;
    end
  end

  // a push onto a full stack is dropped inside the stack
  bfhs_stack u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (back_ctl),
    .push_data (cur_r),
    .top       (back_top),
    .empty     (back_empty)
  );

  bfhs_stack u_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (fwd_ctl),
    .push_data (cur_r),
    .top       (fwd_top),
    .empty     (fwd_empty)
  );

  // current page and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        cur_r <= cur_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_page_r   <= 16'(cur_nxt);
      out_status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-18){1'b0}}, out_status_r, out_page_r};

endmodule

[hw/rtl/bfhs_cell.sv]
// one stack entry cell, loads from its upper or lower neighbor
module bfhs_cell
  import bfhs_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  page_t     from_up,
  input  page_t     from_down,
  output page_t     data
);

  page_t data_r;

  always_ff @(posedge clk) begin
    if (ctl.shift_down) begin
      data_r <= from_up;
    end else if (ctl.shift_up) begin
      data_r <= from_down;
    end
  end

  assign data = data_r;

endmodule

[hw/rtl/bfhs_stack.sv]
// bounded lifo built as a row of shifting cells, top in cell 0
module bfhs_stack
  import bfhs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  stk_ctl_t ctl,
  input  page_t    push_data,
  output page_t    top,
  output logic     empty
);

  cnt_t      count_r, count_nxt;
  page_t     cell_q [STACK_DEPTH];
  cell_ctl_t cell_ctl;
  logic      full;
  logic      do_push;

  assign full    = (count_r == CNT_W'(STACK_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = ctl.push && !full;

  assign cell_ctl.shift_down = do_push;
  assign cell_ctl.shift_up   = ctl.pop;

  always_comb begin
    count_nxt = count_r;
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (do_push) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    page_t up_d, down_d;
    if (i == 0) begin : g_first
      assign up_d = push_data;
    end else begin : g_mid_up
      assign up_d = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign down_d = '0;
    end else begin : g_mid_down
      assign down_d = cell_q[i+1];
    end
    bfhs_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .from_up   (up_d),
      .from_down (down_d),
      .data      (cell_q[i])
    );
  end

  assign top = cell_q[0];

endmodule

[hw/rtl/bfhs_chk.sv]
// port-level checker for the back/forward history stacks, bound to the top
module bfhs_chk
  import bfhs_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // every accepted transaction shows a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted transaction produced no result");

  // a visit makes the given page current with done status
  a_visit: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[1:0] == MODE_VISIT) |=>
      (out_tdata[15:0] == $past(in_tdata[17:2])) && (out_tdata[17:16] == ST_DONE))
    else $error("visit did not make the page current");

  // status is always a defined code and padding is zero
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[17:16] != 2'd3) && (out_tdata[OUT_TDATA_W-1:18] == '0))
    else $error("bad status code or padding");

endmodule

bind back_forward_history_stacks bfhs_chk u_bfhs_chk (.*);

[bench/back_forward_history_stacks_tb.sv]
// self-checking stream testbench for the back/forward navigation history block
`timescale 1ns / 100ps

module back_forward_history_stacks_tb;
  import bfhs_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_ITEMS   = 700;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 20;
  localparam int IDX_W          = $clog2(STACK_DEPTH);

  typedef struct {
    logic [1:0] mode;
    page_t      page;
    bit         drain;  // hold this transaction until all results are back
  } nav_req_t;

  typedef struct {
    page_t      page;
    logic [1:0] status;
  } nav_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [1:0] mode, [17:2] page_id
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [15:0] current_page, [17:16] status

  back_forward_history_stacks u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // predicted history state
  page_t back_hist [STACK_DEPTH];
  page_t fwd_hist  [STACK_DEPTH];
  cnt_t  back_depth = '0;
  cnt_t  fwd_depth  = '0;
  page_t cur_page   = '0;

  nav_req_t    pending_q[$];
  nav_result_t expected_q[$];
  nav_req_t    active_req;

  int total_items  = 0;
  int accepted_cnt = 0;
  int error_cnt    = 0;
  int idle_cycles  = 0;
  int in_gap       = 0;
  int in_calm      = 0;
  int out_stall    = 0;
  int out_calm     = 0;

  // a push onto a full stack is dropped
  function automatic void push_back_hist(input page_t page);
    if (back_depth < STACK_DEPTH) begin
      back_hist[back_depth[IDX_W-1:0]] = page;
      back_depth++;
    end
  endfunction

  function automatic nav_result_t navigate(input logic [1:0] mode, input page_t page);
    nav_result_t r;
    r.status = ST_DONE;
    case (mode)
      MODE_VISIT: begin
        push_back_hist(cur_page);
        fwd_depth = '0;
        cur_page  = page;
      end
      MODE_BACK: begin
        if (back_depth == 0) begin
          r.status = ST_NO_BACK;
        end else begin
          if (fwd_depth < STACK_DEPTH) begin
            fwd_hist[fwd_depth[IDX_W-1:0]] = cur_page;
            fwd_depth++;
          end
          back_depth--;
          cur_page = back_hist[back_depth[IDX_W-1:0]];
        end
      end
      MODE_FORWARD: begin
        if (fwd_depth == 0) begin
          r.status = ST_NO_FORWARD;
        end else begin
          push_back_hist(cur_page);
          fwd_depth--;
          cur_page = fwd_hist[fwd_depth[IDX_W-1:0]];
        end
      end
      default: begin
      end
    endcase
    r.page = cur_page;
    return r;
  endfunction

  // mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int pick_gap(inout int calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_item(input logic [1:0] mode, input page_t page, input bit drain);
    nav_req_t req;
    req.mode  = mode;
    req.page  = page;
    req.drain = drain;
    pending_q.push_back(req);
    total_items++;
  endtask

  task automatic add_burst(input logic [1:0] mode, input int len, inout int cnt);
    for (int i = 0; i < len; i++) begin
      add_item(mode, page_t'($urandom()), 1'b0);
      cnt++;
    end
  endtask

  task automatic build_stimulus();
    int rand_cnt;
    int pick;
    int len;
    logic [1:0] mode;
    rand_cnt = 0;

    // empty stacks, unused mode, page extremes, clear on visit
    add_item(MODE_BACK,    16'h1234, 1'b0);
    add_item(MODE_FORWARD, 16'h4321, 1'b0);
    add_item(MODE_UNUSED,  16'hffff, 1'b0);
    add_item(MODE_VISIT,   16'hffff, 1'b0);
    add_item(MODE_VISIT,   16'h0000, 1'b0);
    add_item(MODE_VISIT,   16'haaaa, 1'b0);
    add_item(MODE_VISIT,   16'h5555, 1'b0);
    add_item(MODE_BACK,    16'h0000, 1'b0);
    add_item(MODE_BACK,    16'hffff, 1'b0);
    add_item(MODE_FORWARD, 16'h0000, 1'b0);
    add_item(MODE_VISIT,   16'h0001, 1'b0);
    add_item(MODE_FORWARD, 16'hffff, 1'b0);
    for (int i = 0; i < 5; i++) add_item(MODE_BACK, 16'h8000, 1'b0);
    add_item(MODE_FORWARD, 16'h7fff, 1'b0);
    add_item(MODE_FORWARD, 16'h0000, 1'b0);
    add_item(MODE_UNUSED,  16'h0000, 1'b0);
    add_item(MODE_VISIT,   16'h8001, 1'b0);
    add_item(MODE_BACK,    16'h0000, 1'b0);

    // sender waits for an empty pipe, then overflows the back stack and walks it
    add_item(MODE_VISIT, page_t'($urandom()), 1'b1);
    rand_cnt++;
    add_burst(MODE_VISIT,   STACK_DEPTH + 6, rand_cnt);
    add_burst(MODE_BACK,    STACK_DEPTH + 4, rand_cnt);
    add_burst(MODE_FORWARD, STACK_DEPTH + 4, rand_cnt);

    while (rand_cnt < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = $urandom_range(10, 40);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 3))
            0, 1:    mode = MODE_VISIT;
            2:       mode = MODE_BACK;
            default: mode = MODE_FORWARD;
          endcase
          add_item(mode, page_t'($urandom()), 1'b0);
          rand_cnt++;
        end
      end else if (pick < 60) begin
        add_burst(MODE_VISIT, $urandom_range(5, 30), rand_cnt);
      end else if (pick < 75) begin
        add_burst(MODE_BACK, $urandom_range(5, 40), rand_cnt);
      end else if (pick < 87) begin
        add_burst(MODE_FORWARD, $urandom_range(5, 40), rand_cnt);
      end else if (pick < 95) begin
        // noise: unused mode, does not count
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) add_item(MODE_UNUSED, page_t'($urandom()), 1'b0);
      end else if (pick < 98) begin
        add_item(MODE_VISIT, page_t'($urandom()), 1'b1);
        rand_cnt++;
      end else begin
        add_burst(MODE_VISIT, STACK_DEPTH + $urandom_range(1, 8), rand_cnt);
      end
    end
  endtask

  // driver: one transaction from the pending queue at a time
  always @(posedge clk) begin
    bit next_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      next_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_q.push_back(navigate(active_req.mode, active_req.page));
        accepted_cnt++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].drain && expected_q.size() != 0)) begin
          active_req = pending_q.pop_front();
          in_tdata   <= {{(IN_TDATA_W-PAGE_BITS-2){1'b0}}, active_req.page, active_req.mode};
          next_valid = 1'b1;
          in_gap     = pick_gap(in_calm);
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // monitor: check each result against the oldest prediction
  always @(posedge clk) begin
    nav_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          error_cnt++;
          $display("%0t: unexpected result, expected none, actual page %h status %0d",
                   $time, out_tdata[15:0], out_tdata[17:16]);
        end else begin
          want = expected_q.pop_front();
          if (out_tdata[15:0] !== want.page) begin
            error_cnt++;
            $display("%0t: current_page mismatch, expected %h actual %h",
                     $time, want.page, out_tdata[15:0]);
          end
          if (out_tdata[17:16] !== want.status) begin
            error_cnt++;
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, out_tdata[17:16]);
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_tvalid && out_tready) out_stall = pick_gap(out_calm);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    wait (accepted_cnt == total_items);
    wait (expected_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_cnt == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
